// File: rtl/smis_pkg.sv
package smis_pkg;

    // Opcode nibbles that do something; every other code only advances the PC.
    typedef enum logic [3:0] {
        OP_LOAD      = 4'h1,
        OP_LOAD_IMM  = 4'h2,
        OP_STORE     = 4'h3,
        OP_COPY      = 4'h4,
        OP_ADD       = 4'h5,
        OP_JUMP      = 4'hB,
        OP_HALT      = 4'hC
    } opcode_t;

    localparam int unsigned NUM_REGS       = 16;
    localparam int unsigned REG_IDX_WIDTH  = 4;
    localparam int unsigned PC_WIDTH       = 8;
    localparam int unsigned SHOW_WIDTH     = 32;
    localparam logic [7:0]  SHOW_ADDR      = 8'h00;
    localparam logic [7:0]  PC_STEP        = 8'd2;
    localparam logic [7:0]  PROG_LEN_RESET = 8'd128;

endpackage

// File: rtl/smis_instr_if.sv
interface smis_instr_if;
    logic       valid;
    logic       ready;
    logic [3:0] opcode;
    logic [3:0] reg_field;
    logic [7:0] operand;

    modport source (output valid, output opcode, output reg_field, output operand,
                    input ready);
    modport sink   (input valid, input opcode, input reg_field, input operand,
                    output ready);
endinterface

// File: rtl/smis_result_if.sv
interface smis_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  next_pc;
    logic        halted;
    logic        carry_out;
    logic        jump_rejected;
    logic        missing_source;
    logic        show_valid;
    logic [31:0] show_value;

    modport source (output valid, output next_pc, output halted, output carry_out,
                    output jump_rejected, output missing_source, output show_valid,
                    output show_value, input ready);
    modport sink   (input valid, input next_pc, input halted, input carry_out,
                    input jump_rejected, input missing_source, input show_valid,
                    input show_value, output ready);
endinterface

// File: rtl/smis_regfile.sv
module smis_regfile #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   rd_en,
    input  logic [smis_pkg::REG_IDX_WIDTH-1:0]     rd_addr_a,
    input  logic [smis_pkg::REG_IDX_WIDTH-1:0]     rd_addr_b,
    input  logic                                   wr_en,
    input  logic [smis_pkg::REG_IDX_WIDTH-1:0]     wr_addr,
    input  logic [DATA_WIDTH-1:0]                  wr_data,
    output logic [DATA_WIDTH-1:0]                  val_a,
    output logic [DATA_WIDTH-1:0]                  val_b,
    output logic                                   written_a,
    output logic [DATA_WIDTH-1:0]                  val_zero
);

    logic [DATA_WIDTH-1:0]                  mem [smis_pkg::NUM_REGS];
    logic [DATA_WIDTH-1:0]                  rdata_a_reg;
    logic [DATA_WIDTH-1:0]                  rdata_b_reg;
    logic [smis_pkg::REG_IDX_WIDTH-1:0]     addr_a_reg;
    logic [smis_pkg::REG_IDX_WIDTH-1:0]     addr_b_reg;
    logic [smis_pkg::NUM_REGS-1:0]          written_reg;
    logic                                   fwd_valid_reg;
    logic [smis_pkg::REG_IDX_WIDTH-1:0]     fwd_addr_reg;
    logic [DATA_WIDTH-1:0]                  fwd_data_reg;
    logic [DATA_WIDTH-1:0]                  zero_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_a_reg <= mem[rd_addr_a];
            rdata_b_reg <= mem[rd_addr_b];
            addr_a_reg  <= rd_addr_a;
            addr_b_reg  <= rd_addr_b;
        end
        if (wr_en)
        begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
    end

    // Written flags, the forwarding marker and the register 0 copy need a known reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg   <= '0;
            fwd_valid_reg <= 1'b0;
            zero_reg      <= '0;
        end
        else if (wr_en)
        begin
            written_reg[wr_addr] <= 1'b1;
            fwd_valid_reg        <= 1'b1;
            if (wr_addr == '0)
            begin
                zero_reg <= wr_data;
            end
        end
    end

    // The last write may have landed in the same edge as the read; it is the newest value.
    always_comb
    begin
        if (!written_reg[addr_a_reg])
            val_a = '0;
        else if (fwd_valid_reg && fwd_addr_reg == addr_a_reg)
            val_a = fwd_data_reg;
        else
            val_a = rdata_a_reg;

        if (!written_reg[addr_b_reg])
            val_b = '0;
        else if (fwd_valid_reg && fwd_addr_reg == addr_b_reg)
            val_b = fwd_data_reg;
        else
            val_b = rdata_b_reg;
    end

    assign written_a = written_reg[addr_a_reg];
    assign val_zero  = zero_reg;

endmodule

// File: rtl/smis_datamem.sv
module smis_datamem #(
    parameter int unsigned DATA_WIDTH   = 32,
    parameter int unsigned MEMORY_DEPTH = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rd_en,
    input  logic [$clog2(MEMORY_DEPTH)-1:0]   rd_addr,
    input  logic                              wr_en,
    input  logic [$clog2(MEMORY_DEPTH)-1:0]   wr_addr,
    input  logic [DATA_WIDTH-1:0]             wr_data,
    output logic [DATA_WIDTH-1:0]             rd_data,
    output logic                              rd_written
);

    localparam int unsigned AW = $clog2(MEMORY_DEPTH);

    logic [DATA_WIDTH-1:0]     mem [MEMORY_DEPTH];
    logic [DATA_WIDTH-1:0]     rdata_reg;
    logic [AW-1:0]             addr_reg;
    logic [MEMORY_DEPTH-1:0]   written_reg;
    logic                      fwd_valid_reg;
    logic [AW-1:0]             fwd_addr_reg;
    logic [DATA_WIDTH-1:0]     fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
            addr_reg  <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg   <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            written_reg[wr_addr] <= 1'b1;
            fwd_valid_reg        <= 1'b1;
        end
    end

    assign rd_written = written_reg[addr_reg];
    assign rd_data    = (fwd_valid_reg && fwd_addr_reg == addr_reg) ? fwd_data_reg : rdata_reg;

endmodule

// File: rtl/simple_machine_instruction_step.sv
// Channel   Direction  Transaction carries
// -------   ---------  -------------------------------------------------------------
// instr     in         opcode, reg_field, operand: one instruction
// result    out        next_pc, halted, carry_out, jump_rejected, missing_source,
//                      show_valid, show_value: one status record per instruction
// cfg       in         cfg_we / cfg_wdata: program length, no handshake
//
// One instruction per cycle is sustained while result.ready holds. Reads are issued at
// the accepting edge, and the instruction executes from the execute-stage registers and
// writes back when it commits into the output register, which drives result.valid.
// Reset clears the register and memory written flags, the PC and the halt flag at
// once; no clearing pass is needed. A stalled result holds the execute stage, which
// in turn holds the input; otherwise the input stays ready.
module simple_machine_instruction_step #(
    parameter int unsigned DATA_WIDTH   = 32,
    parameter int unsigned MEMORY_DEPTH = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    smis_instr_if.sink            instr,
    smis_result_if.source         result,
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_wdata
);

    localparam int unsigned AW = $clog2(MEMORY_DEPTH);

    // Issue side: handshake and the execute stage's instruction registers.
    logic                                   accept;
    logic                                   commit;
    logic                                   s1_valid_reg;
    smis_pkg::opcode_t                      s1_op_reg;
    logic [3:0]                             s1_reg_reg;
    logic [7:0]                             s1_arg_reg;
    logic [smis_pkg::REG_IDX_WIDTH-1:0]     issue_addr_a;

    // Architectural state held in flip-flops.
    logic [smis_pkg::PC_WIDTH-1:0]          pc_reg;
    logic                                   halt_reg;
    logic [7:0]                             prog_len_reg;

    // Output register.
    logic                                   out_valid_reg;
    logic [7:0]                             next_pc_reg;
    logic                                   halted_reg;
    logic                                   carry_reg;
    logic                                   rejected_reg;
    logic                                   missing_reg;
    logic                                   show_valid_reg;
    logic [smis_pkg::SHOW_WIDTH-1:0]        show_value_reg;

    // Execute results.
    logic [7:0]                             next_pc_next;
    logic                                   halt_next;
    logic                                   carry_next;
    logic                                   rejected_next;
    logic                                   missing_next;
    logic                                   show_valid_next;
    logic [smis_pkg::SHOW_WIDTH-1:0]        show_value_next;
    logic                                   rf_we;
    logic [smis_pkg::REG_IDX_WIDTH-1:0]     rf_waddr;
    logic [DATA_WIDTH-1:0]                  rf_wdata;
    logic                                   dm_we;
    logic [DATA_WIDTH-1:0]                  dm_rdata;
    logic                                   dm_written;
    logic [DATA_WIDTH-1:0]                  val_a;
    logic [DATA_WIDTH-1:0]                  val_b;
    logic                                   written_a;
    logic [DATA_WIDTH-1:0]                  val_zero;
    logic [DATA_WIDTH:0]                    sum;
    logic                                   addr_in_range;

    // The execute stage moves on whenever the output register is free or being emptied.
    assign commit      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign instr.ready = !s1_valid_reg || commit;
    assign accept      = instr.valid && instr.ready;

    // Copy and add name their first source in the operand's high nibble; store and
    // jump name it in the register field.
    assign issue_addr_a = (instr.opcode == smis_pkg::OP_COPY || instr.opcode == smis_pkg::OP_ADD)
                          ? instr.operand[7:4] : instr.reg_field;

    smis_regfile #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (issue_addr_a),
        .rd_addr_b (instr.operand[3:0]),
        .wr_en     (rf_we),
        .wr_addr   (rf_waddr),
        .wr_data   (rf_wdata),
        .val_a     (val_a),
        .val_b     (val_b),
        .written_a (written_a),
        .val_zero  (val_zero)
    );

    smis_datamem #(
        .DATA_WIDTH   (DATA_WIDTH),
        .MEMORY_DEPTH (MEMORY_DEPTH)
    ) u_datamem (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (accept),
        .rd_addr    (instr.operand[AW-1:0]),
        .wr_en      (dm_we),
        .wr_addr    (s1_arg_reg[AW-1:0]),
        .wr_data    (val_a),
        .rd_data    (dm_rdata),
        .rd_written (dm_written)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg  <= smis_pkg::opcode_t'(instr.opcode);
            s1_reg_reg <= instr.reg_field;
            s1_arg_reg <= instr.operand;
        end
        if (commit)
        begin
            next_pc_reg    <= next_pc_next;
            halted_reg     <= halt_next;
            carry_reg      <= carry_next;
            rejected_reg   <= rejected_next;
            missing_reg    <= missing_next;
            show_valid_reg <= show_valid_next;
            show_value_reg <= show_value_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            prog_len_reg  <= smis_pkg::PROG_LEN_RESET;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (commit)
                s1_valid_reg <= 1'b0;

            if (commit)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            if (commit)
            begin
                pc_reg   <= next_pc_next;
                halt_reg <= halt_next;
            end

            if (cfg_we)
                prog_len_reg <= cfg_wdata;
        end
    end

    // Addresses at or past the memory depth are neither stored nor loaded.
    assign addr_in_range = {1'b0, s1_arg_reg} < 9'(MEMORY_DEPTH);
    assign sum           = {1'b0, val_a} + {1'b0, val_b};

    always_comb
    begin
        next_pc_next    = pc_reg + smis_pkg::PC_STEP;
        halt_next       = halt_reg;
        carry_next      = 1'b0;
        rejected_next   = 1'b0;
        missing_next    = 1'b0;
        show_valid_next = 1'b0;
        show_value_next = '0;
        rf_we           = 1'b0;
        rf_waddr        = s1_reg_reg;
        rf_wdata        = val_a;
        dm_we           = 1'b0;

        if (halt_reg)
        begin
            // Once halted, instructions are ignored and the PC stays put.
            next_pc_next = pc_reg;
        end
        else
        begin
            case (s1_op_reg)
                smis_pkg::OP_LOAD:
                begin
                    if (addr_in_range && dm_written)
                    begin
                        rf_we    = commit;
                        rf_wdata = dm_rdata;
                    end
                end
                smis_pkg::OP_LOAD_IMM:
                begin
                    rf_we    = commit;
                    rf_wdata = DATA_WIDTH'(s1_arg_reg);
                end
                smis_pkg::OP_STORE:
                begin
                    if (s1_arg_reg == smis_pkg::SHOW_ADDR)
                    begin
                        show_valid_next = 1'b1;
                        show_value_next = smis_pkg::SHOW_WIDTH'(val_a);
                    end
                    else if (addr_in_range)
                    begin
                        dm_we = commit;
                    end
                end
                smis_pkg::OP_COPY:
                begin
                    if (written_a)
                    begin
                        rf_we    = commit;
                        rf_waddr = s1_arg_reg[3:0];
                    end
                    else
                    begin
                        missing_next = 1'b1;
                    end
                end
                smis_pkg::OP_ADD:
                begin
                    rf_we      = commit;
                    rf_wdata   = sum[DATA_WIDTH-1:0];
                    carry_next = sum[DATA_WIDTH];
                end
                smis_pkg::OP_JUMP:
                begin
                    if (val_a == val_zero)
                    begin
                        // Target is a byte address; it names instruction target/2.
                        if ({1'b0, s1_arg_reg[7:1]} < prog_len_reg)
                            next_pc_next = {s1_arg_reg[7:1], 1'b0};
                        else
                            rejected_next = 1'b1;
                    end
                end
                smis_pkg::OP_HALT:
                begin
                    halt_next    = 1'b1;
                    next_pc_next = pc_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.next_pc        = next_pc_reg;
    assign result.halted         = halted_reg;
    assign result.carry_out      = carry_reg;
    assign result.jump_rejected  = rejected_reg;
    assign result.missing_source = missing_reg;
    assign result.show_valid     = show_valid_reg;
    assign result.show_value     = show_value_reg;

endmodule

// File: test/smis_status_checker.sv
module smis_status_checker (
    input  logic   clk,
    input  logic   rst_n,
    smis_instr_if  instr,
    smis_result_if result,
    input  logic   cfg_we,
    input  logic [7:0] cfg_wdata,
    output int     fail_count,
    output int     pending,
    output int     checked,
    output int     carries,
    output int     rejects,
    output int     shows
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  next_pc;
        logic        halted;
        logic        carry_out;
        logic        jump_rejected;
        logic        missing_source;
        logic        show_valid;
        logic [31:0] show_value;
    } status_t;

    // Private copy of the machine state, advanced once per accepted instruction.
    logic [31:0] regs     [smis_pkg::NUM_REGS];
    logic        reg_wr   [smis_pkg::NUM_REGS];
    logic [31:0] mem      [256];
    logic        mem_wr   [256];
    logic [7:0]  pc;
    logic        halt_flag;
    logic [7:0]  prog_len;

    status_t predicted_status [$];

    function automatic status_t execute_instr(input logic [3:0] op, input logic [3:0] rf,
                                              input logic [7:0] arg);
        status_t     st;
        logic [3:0]  src_a;
        logic [3:0]  src_b;
        logic [32:0] sum;
        st    = '0;
        src_a = arg[7:4];
        src_b = arg[3:0];
        st.next_pc = pc + smis_pkg::PC_STEP;
        if (halt_flag)
        begin
            st.next_pc = pc;
        end
        else
        begin
            case (op)
                smis_pkg::OP_LOAD:
                begin
                    if (mem_wr[arg])
                    begin
                        regs[rf]   = mem[arg];
                        reg_wr[rf] = 1'b1;
                    end
                end
                smis_pkg::OP_LOAD_IMM:
                begin
                    regs[rf]   = {24'd0, arg};
                    reg_wr[rf] = 1'b1;
                end
                smis_pkg::OP_STORE:
                begin
                    if (arg == smis_pkg::SHOW_ADDR)
                    begin
                        st.show_valid = 1'b1;
                        st.show_value = regs[rf];
                    end
                    else
                    begin
                        mem[arg]    = regs[rf];
                        mem_wr[arg] = 1'b1;
                    end
                end
                smis_pkg::OP_COPY:
                begin
                    if (reg_wr[src_a])
                    begin
                        regs[src_b]   = regs[src_a];
                        reg_wr[src_b] = 1'b1;
                    end
                    else
                    begin
                        st.missing_source = 1'b1;
                    end
                end
                smis_pkg::OP_ADD:
                begin
                    sum          = {1'b0, regs[src_a]} + {1'b0, regs[src_b]};
                    st.carry_out = sum[32];
                    regs[rf]     = sum[31:0];
                    reg_wr[rf]   = 1'b1;
                end
                smis_pkg::OP_JUMP:
                begin
                    if (regs[rf] == regs[0])
                    begin
                        if ({1'b0, arg[7:1]} < prog_len)
                            st.next_pc = {arg[7:1], 1'b0};
                        else
                            st.jump_rejected = 1'b1;
                    end
                end
                smis_pkg::OP_HALT:
                begin
                    halt_flag  = 1'b1;
                    st.next_pc = pc;
                end
                default:
                begin
                end
            endcase
        end
        pc        = st.next_pc;
        st.halted = halt_flag;
        return st;
    endfunction

    function automatic int field_mismatch(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        status_t want;
        status_t got;
        int      errs;
        if (!rst_n)
        begin
            for (int i = 0; i < smis_pkg::NUM_REGS; i++)
            begin
                regs[i]   = '0;
                reg_wr[i] = 1'b0;
            end
            for (int i = 0; i < 256; i++)
            begin
                mem_wr[i] = 1'b0;
            end
            pc        = '0;
            halt_flag = 1'b0;
            prog_len  = smis_pkg::PROG_LEN_RESET;
            predicted_status.delete();
            fail_count <= 0;
            pending    <= 0;
            checked    <= 0;
            carries    <= 0;
            rejects    <= 0;
            shows      <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg_we)
                prog_len = cfg_wdata;
            if (result.valid && result.ready)
            begin
                got.next_pc        = result.next_pc;
                got.halted         = result.halted;
                got.carry_out      = result.carry_out;
                got.jump_rejected  = result.jump_rejected;
                got.missing_source = result.missing_source;
                got.show_valid     = result.show_valid;
                got.show_value     = result.show_value;
                if (predicted_status.size() == 0)
                begin
                    $display("%0t ns: unexpected result transaction, expected none, actual next_pc %0h",
                             $time, got.next_pc);
                    errs++;
                end
                else
                begin
                    want = predicted_status.pop_front();
                    errs += field_mismatch("next_pc", 32'(want.next_pc), 32'(got.next_pc));
                    errs += field_mismatch("halted", 32'(want.halted), 32'(got.halted));
                    errs += field_mismatch("carry_out", 32'(want.carry_out),
                                           32'(got.carry_out));
                    errs += field_mismatch("jump_rejected", 32'(want.jump_rejected),
                                           32'(got.jump_rejected));
                    errs += field_mismatch("missing_source", 32'(want.missing_source),
                                           32'(got.missing_source));
                    errs += field_mismatch("show_valid", 32'(want.show_valid),
                                           32'(got.show_valid));
                    errs += field_mismatch("show_value", want.show_value, got.show_value);
                    checked <= checked + 1;
                    carries <= carries + int'(want.carry_out);
                    rejects <= rejects + int'(want.jump_rejected);
                    shows   <= shows + int'(want.show_valid);
                end
            end
            if (instr.valid && instr.ready)
                predicted_status.insert(predicted_status.size(),
                                        execute_instr(instr.opcode, instr.reg_field,
                                                      instr.operand));
            fail_count <= fail_count + errs;
            pending    <= predicted_status.size();
        end
    end

endmodule

// File: test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Number of random draws under each program length setting; some draws issue
    // two instructions.
    localparam int PHASE_ITEMS = 310;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    smis_instr_if  instr_ch ();
    smis_result_if result_ch ();

    int fail_count;
    int pending;
    int checked;
    int carries;
    int rejects;
    int shows;

    // Idling controls shared between the sender and the receiver processes. A
    // non-zero stall_request asks the receiver to hold off for that many cycles.
    bit src_gaps      = 1'b1;
    bit sink_gaps     = 1'b1;
    int stall_request = 0;
    int settings_used = 1;

    // Addresses that have been stored to, so that a load never reads a word
    // that was never written.
    logic [7:0] stored_addrs [$];

    simple_machine_instruction_step DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .instr     (instr_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    smis_status_checker status_monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .instr      (instr_ch),
        .result     (result_ch),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .carries    (carries),
        .rejects    (rejects),
        .shows      (shows)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offers one instruction and returns at the edge where the transaction is
    // accepted. Valid is left high on return, so back-to-back calls keep it high
    // without a second assignment in the same time step; it is only lowered in
    // an idle gap or when the caller lets the block drain.
    task automatic send_instr(input logic [3:0] op, input logic [3:0] rf,
                              input logic [7:0] arg);
        if (src_gaps)
        begin
            while ($urandom_range(0, 99) < 20)
            begin
                instr_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        instr_ch.valid     <= 1'b1;
        instr_ch.opcode    <= op;
        instr_ch.reg_field <= rf;
        instr_ch.operand   <= arg;
        do
            @(posedge clk);
        while (!instr_ch.ready);
    endtask

    // Stops offering and waits until every expected result has been taken, then
    // allows a few more cycles than the two-stage pipeline needs. The first edge
    // lets the checker's count catch up with a transaction taken on this edge.
    task automatic wait_idle();
        instr_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // The program length is only changed while the pipeline is empty.
    task automatic set_program_length(input logic [7:0] len);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // Receiver: accepts results with random gaps, or with none when sink_gaps is clear, or
    // holds off completely for a requested number of cycles, counted here.
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_request > 0)
            begin
                stall_left    = stall_request;
                stall_request = 0;
            end
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (sink_gaps)
            begin
                result_ch.ready <= ($urandom_range(0, 99) >= 20);
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int         pick;
        logic [3:0] op;
        logic [3:0] rf;
        logic [3:0] ra;
        logic [3:0] rb;
        logic [7:0] addr;
        logic [7:0] plen;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        instr_ch.valid     <= 1'b0;
        instr_ch.opcode    <= '0;
        instr_ch.reg_field <= '0;
        instr_ch.operand   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the program length at its reset value. Straight
        // after reset no register has been written, so a copy reports a missing
        // source and every read of a register gives zero.
        send_instr(smis_pkg::OP_COPY, 4'd0, 8'h5A);
        send_instr(smis_pkg::OP_STORE, 4'd3, smis_pkg::SHOW_ADDR);
        send_instr(smis_pkg::OP_ADD, 4'd1, 8'h23);
        send_instr(smis_pkg::OP_LOAD_IMM, 4'd2, 8'hFF);
        send_instr(smis_pkg::OP_LOAD_IMM, 4'd3, 8'h00);
        send_instr(smis_pkg::OP_LOAD_IMM, 4'd15, 8'hFF);
        send_instr(smis_pkg::OP_ADD, 4'd4, 8'h2F);
        // A store to the top address followed by a load back and a show of it.
        send_instr(smis_pkg::OP_STORE, 4'd4, 8'hFF);
        stored_addrs.insert(stored_addrs.size(), 8'hFF);
        send_instr(smis_pkg::OP_LOAD, 4'd5, 8'hFF);
        send_instr(smis_pkg::OP_STORE, 4'd5, smis_pkg::SHOW_ADDR);
        // A store overwrites an earlier word at the same address.
        send_instr(smis_pkg::OP_STORE, 4'd2, 8'hFF);
        send_instr(smis_pkg::OP_LOAD, 4'd6, 8'hFF);
        send_instr(smis_pkg::OP_COPY, 4'd0, 8'h56);
        send_instr(smis_pkg::OP_STORE, 4'd6, smis_pkg::SHOW_ADDR);
        // Register 0 always equals itself, so this jump is taken to the
        // highest target with bit 0 cleared; the next one compares 0xFF with 0.
        send_instr(smis_pkg::OP_JUMP, 4'd0, 8'hFF);
        send_instr(smis_pkg::OP_JUMP, 4'd2, 8'h40);
        send_instr(smis_pkg::OP_JUMP, 4'd0, 8'h00);
        // Unused opcodes only advance the PC.
        send_instr(4'h0, 4'd0, 8'h00);
        send_instr(4'hF, 4'd15, 8'hFF);

        // With a one-instruction program only target bytes 0 and 1 are in range.
        set_program_length(8'd1);
        send_instr(smis_pkg::OP_JUMP, 4'd0, 8'h02);
        send_instr(smis_pkg::OP_JUMP, 4'd0, 8'h01);

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0:       plen = 8'd64;
                1:       plen = smis_pkg::PROG_LEN_RESET;
                2:       plen = 8'($urandom_range(2, 127));
                3:       plen = 8'd1;
                default: plen = 8'd100;
            endcase
            set_program_length(plen);
            // The fourth phase runs with no idling on either side at all.
            src_gaps  = (p != 3);
            sink_gaps = (p != 3);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // In the second phase the receiver holds off for a long stretch
                // while the sender keeps offering, so the pipeline fills and the
                // input stalls; in the last one the sender waits for a full drain.
                if (p == 1 && n == 100)
                begin
                    src_gaps      = 1'b0;
                    stall_request = 64;
                end
                if (p == 1 && n == 140)
                    src_gaps = 1'b1;
                if (p == 4 && n == 175)
                    wait_idle();

                pick = $urandom_range(0, 99);
                rf   = 4'($urandom);
                ra   = 4'($urandom);
                rb   = 4'($urandom);
                if (pick < 14)
                begin
                    send_instr(smis_pkg::OP_LOAD_IMM, rf, 8'($urandom));
                end
                else if (pick < 34)
                begin
                    // Repeated adds grow the values until they carry out.
                    send_instr(smis_pkg::OP_ADD, rf, {ra, rb});
                end
                else if (pick < 46 || (pick < 56 && stored_addrs.size() == 0))
                begin
                    if ($urandom_range(0, 7) == 0)
                        addr = smis_pkg::SHOW_ADDR;
                    else if ($urandom_range(0, 1) == 1)
                        addr = 8'($urandom_range(1, 15));
                    else
                        addr = 8'($urandom_range(1, 255));
                    if (addr != smis_pkg::SHOW_ADDR)
                        stored_addrs.insert(stored_addrs.size(), addr);
                    send_instr(smis_pkg::OP_STORE, rf, addr);
                end
                else if (pick < 56)
                begin
                    addr = stored_addrs[$urandom_range(0, stored_addrs.size() - 1)];
                    send_instr(smis_pkg::OP_LOAD, rf, addr);
                end
                else if (pick < 66)
                begin
                    send_instr(smis_pkg::OP_COPY, rf, {ra, rb});
                end
                else if (pick < 78)
                begin
                    // Either register 0 itself, which always matches, or any other.
                    if ($urandom_range(0, 2) == 0)
                        rf = 4'd0;
                    send_instr(smis_pkg::OP_JUMP, rf, 8'($urandom));
                end
                else if (pick < 90)
                begin
                    // Copy register 0 into a register and jump on it, so that once
                    // register 0 has been written the target check decides the outcome.
                    send_instr(smis_pkg::OP_COPY, ra, {4'd0, rf});
                    send_instr(smis_pkg::OP_JUMP, rf, 8'($urandom));
                end
                else
                begin
                    do
                        op = 4'($urandom);
                    while (op == smis_pkg::OP_LOAD || op == smis_pkg::OP_LOAD_IMM ||
                           op == smis_pkg::OP_STORE || op == smis_pkg::OP_COPY ||
                           op == smis_pkg::OP_ADD || op == smis_pkg::OP_JUMP ||
                           op == smis_pkg::OP_HALT);
                    send_instr(op, rf, 8'($urandom));
                end
            end
        end

        // The halt comes last, because nothing executes after it until reset;
        // the instructions that follow must leave the PC where it stopped.
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        send_instr(smis_pkg::OP_HALT, 4'd7, 8'h33);
        send_instr(smis_pkg::OP_LOAD_IMM, 4'd1, 8'hAA);
        send_instr(smis_pkg::OP_JUMP, 4'd0, 8'h10);
        send_instr(smis_pkg::OP_STORE, 4'd2, smis_pkg::SHOW_ADDR);

        wait_idle();
        repeat (4) @(posedge clk);

        $display("Checked %0d instruction results over %0d program length settings,", checked,
                 settings_used);
        $display("including %0d carries, %0d rejected jumps and %0d register shows.", carries,
                 rejects, shows);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog: a correct run finishes well inside this time.
    initial
    begin : watchdog
        #2ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: files.f
rtl/smis_pkg.sv
rtl/smis_instr_if.sv
rtl/smis_result_if.sv
rtl/smis_regfile.sv
rtl/smis_datamem.sv
rtl/simple_machine_instruction_step.sv
test/smis_status_checker.sv
test/tb_top.sv
